/* rtl/trapezoidal_velocity_profiler_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the trapezoidal velocity profiler
// Immediate-cycle and next-cycle implications, sampled on the rising clock
// edge and masked while reset is high.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOIDAL_VELOCITY_PROFILER_TOP_ASSERT_SVH
`define TRAPEZOIDAL_VELOCITY_PROFILER_TOP_ASSERT_SVH

// cons must hold in the same cycle as ante
`define TVP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define TVP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/tvp_pkg.sv */
// ----------------------------------------------------------------------------
// tvp_pkg
// Widths, reset values, codes and the sequencer state type shared by the
// velocity profiler modules.
// ----------------------------------------------------------------------------
package tvp_pkg;

   // field widths (all unsigned Q formats unless noted)
   localparam int DIST_W      = 24;   // Q8.16
   localparam int SPEED_W     = 18;   // Q2.16
   localparam int DT_W        = 16;   // Q0.16
   localparam int ANG_W       = 19;   // signed Q2.16
   localparam int LOOK_W      = DIST_W + 1;
   localparam int RAMP_W      = 35;
   localparam int STEP_DN_W   = 21;
   localparam int SCHED_W     = 22;

   // bus widths
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 24;

   // serial multiplier: multiplicand x multiplier, one multiplier bit a cycle
   localparam int MUL_MC_W    = 25;
   localparam int MUL_MP_W    = 18;
   localparam int MUL_PR_W    = MUL_MC_W + MUL_MP_W;
   localparam int MUL_CNT_W   = $clog2(MUL_MP_W);

   // serial divider: one quotient bit a cycle
   localparam int DIV_NUM_W   = 36;
   localparam int DIV_DEN_W   = 19;
   localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);

   // serial square root: one root bit a cycle
   localparam int SQRT_RAD_W  = 44;
   localparam int SQRT_ROOT_W = SQRT_RAD_W / 2;
   localparam int SQRT_REM_W  = SQRT_ROOT_W + 3;
   localparam int SQRT_CNT_W  = $clog2(SQRT_ROOT_W);

   // register reset values
   localparam logic [DIST_W-1:0]  SEG_LEN_RST   = 24'd327680;
   localparam logic [SPEED_W-1:0] SPD_LIM_RST   = 18'd65536;
   localparam logic [SPEED_W-1:0] ACC_LIM_RST   = 18'd65536;
   localparam logic [DT_W-1:0]    TIME_STEP_RST = 16'd6554;

   // step-down is 6/5 of a*dt; the /5 goes through the divider
   localparam logic [DIV_DEN_W-1:0] STEP_DN_DIVISOR = 19'd5;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SEG_LEN   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPD_LIM   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACC_LIM   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIME_STEP = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MODE      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_TURN_DIR  = 3'd5;

   typedef enum logic [1:0] {
      PH_ACCEL  = 2'd0,
      PH_CRUISE = 2'd1,
      PH_DECEL  = 2'd2
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_DIST,
      ST_MUL_LOOK,
      ST_MUL_VV,
      ST_DIV_RAMP,
      ST_ENDS,
      ST_MUL_ADT,
      ST_DIV_DOWN,
      ST_PHASE,
      ST_MUL_ROOT,
      ST_SQRT,
      ST_STEP,
      ST_OUT
   } state_type;

endpackage

/* rtl/trapezoidal_velocity_profiler_top.sv */
// ----------------------------------------------------------------------------
// Trapezoidal velocity profiler - per word: five serial multiplies, two serial
// divides and a serial root plus control; cruise ticks skip one multiply and the
// root, and a finished segment skips all of them.
// One word in flight; the next is taken once the result sits in the output reg.
// Synchronous active-high reset: registers to defaults, motion state to zero.
// ----------------------------------------------------------------------------
module trapezoidal_velocity_profiler_top (
   input  logic                             clock,
   input  logic                             reset,
   // tick words
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tvp_pkg::REQ_TDATA_W-1:0]  req_tdata,   // [0] restart
   // speed commands
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tvp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // [17:0] linear_speed,
                                                         // [36:18] angular_speed
   output logic                             rsp_tlast,   // segment_done
   output logic [1:0]                       rsp_tuser,   // phase
   // register writes
   input  logic                             csr_we,
   input  logic [tvp_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [tvp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DW = tvp_pkg::DIST_W;
   localparam int SW = tvp_pkg::SPEED_W;
   localparam int TW = tvp_pkg::DT_W;
   localparam int AW = tvp_pkg::ANG_W;
   localparam int LW = tvp_pkg::LOOK_W;
   localparam int KW = tvp_pkg::SCHED_W;

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   logic [DW-1:0] seg_len_ff, seg_len_in;
   logic [SW-1:0] spd_lim_ff, spd_lim_in;
   logic [SW-1:0] acc_lim_ff, acc_lim_in;
   logic [TW-1:0] t_step_ff, t_step_in;
   logic          mode_ff, mode_in;
   logic          turn_dir_ff, turn_dir_in;

   // motion state
   logic [DW-1:0] dist_ff, dist_in;
   logic [SW-1:0] spd_now_ff, spd_now_in;
   logic [SW-1:0] spd_prev_ff, spd_prev_in;

   // per-tick work registers
   tvp_pkg::state_type state_ff, state_in;
   tvp_pkg::phase_type phase_ff, phase_in;
   logic [LW-1:0]                 look_ff, look_in;      // look-ahead distance
   logic [tvp_pkg::RAMP_W-1:0]    ramp_ff, ramp_in;      // V^2 / 2a
   logic [DW-1:0]                 acc_end_ff, acc_end_in;
   logic [DW-1:0]                 cru_end_ff, cru_end_in;
   logic [SW-1:0]                 step_up_ff, step_up_in;
   logic [tvp_pkg::STEP_DN_W-1:0] step_dn_ff, step_dn_in;
   logic [KW-1:0]                 sched_ff, sched_in;

   // pending result, held until the output register is free
   logic [SW-1:0] pend_lin_ff, pend_lin_in;
   logic [AW-1:0] pend_ang_ff, pend_ang_in;
   logic          pend_done_ff, pend_done_in;

   // output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tvp_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic [1:0]                      rsp_user_ff, rsp_user_in;

   // ------------------------------------------------------------------------
   // Shared serial units
   // ------------------------------------------------------------------------
   logic                             mul_start, mul_done;
   logic [tvp_pkg::MUL_MC_W-1:0]     mul_mcand;
   logic [tvp_pkg::MUL_MP_W-1:0]     mul_mplier;
   logic [tvp_pkg::MUL_PR_W-1:0]     mul_product;
   logic                             div_start, div_done;
   logic [tvp_pkg::DIV_NUM_W-1:0]    div_num, div_quot;
   logic [tvp_pkg::DIV_DEN_W-1:0]    div_den;
   logic                             sqrt_start, sqrt_done;
   logic [tvp_pkg::SQRT_RAD_W-1:0]   sqrt_rad;
   logic [tvp_pkg::SQRT_ROOT_W-1:0]  sqrt_root;

   tvp_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .done    (mul_done),
      .product (mul_product)
   );

   tvp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   tvp_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .rad   (sqrt_rad),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   // ------------------------------------------------------------------------
   // Datapath helpers
   // ------------------------------------------------------------------------
   logic [SW-1:0] acc_eff;          // zero acceleration acts as one LSB
   logic [DW:0]   dist_sum;         // distance plus trapezoid increment
   logic          short_seg;        // ramps overlap: no cruise phase
   logic [36:0]   six_adt;          // 6 * a * dt
   logic [KW-1:0] spd_w, up_w, dn_w, lim_w, cmd_w, sched_cmp;
   logic [SW-1:0] cmd;

   assign acc_eff   = (acc_lim_ff == '0) ? SW'(1) : acc_lim_ff;
   assign dist_sum  = {1'b0, dist_ff} + {7'b0, mul_product[34:17]};
   assign short_seg = ({ramp_ff, 1'b0} > {12'b0, seg_len_ff});
   assign six_adt   = {1'b0, mul_product[33:0], 2'b00} + {2'b00, mul_product[33:0], 1'b0};

   // speed command: slew toward the scheduled speed, then cap at the limit
   assign spd_w     = {4'b0, spd_now_ff};
   assign up_w      = spd_w + {4'b0, step_up_ff};
   assign dn_w      = {1'b0, step_dn_ff};
   assign lim_w     = {4'b0, spd_lim_ff};
   assign sched_cmp = sched_ff;

   always_comb begin
      if (spd_w < sched_cmp) begin
         cmd_w = (up_w > sched_cmp) ? sched_cmp : up_w;
      end else if (spd_w > sched_cmp) begin
         // a decrement that would undershoot (or wrap) lands on the schedule
         if ((spd_w >= dn_w) && ((spd_w - dn_w) > sched_cmp)) begin
            cmd_w = spd_w - dn_w;
         end else begin
            cmd_w = sched_cmp;
         end
      end else begin
         cmd_w = spd_w;
      end
      if (cmd_w > lim_w) begin
         cmd = spd_lim_ff;
      end else begin
         cmd = cmd_w[SW-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      seg_len_in   = seg_len_ff;
      spd_lim_in   = spd_lim_ff;
      acc_lim_in   = acc_lim_ff;
      t_step_in    = t_step_ff;
      mode_in      = mode_ff;
      turn_dir_in  = turn_dir_ff;
      dist_in      = dist_ff;
      spd_now_in   = spd_now_ff;
      spd_prev_in  = spd_prev_ff;
      look_in      = look_ff;
      ramp_in      = ramp_ff;
      acc_end_in   = acc_end_ff;
      cru_end_in   = cru_end_ff;
      step_up_in   = step_up_ff;
      step_dn_in   = step_dn_ff;
      sched_in     = sched_ff;
      pend_lin_in  = pend_lin_ff;
      pend_ang_in  = pend_ang_ff;
      pend_done_in = pend_done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      req_tready   = 1'b0;
      mul_start    = 1'b0;
      mul_mcand    = '0;
      mul_mplier   = '0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      sqrt_start   = 1'b0;
      sqrt_rad     = '0;

      // register writes; the user must make them arrive only while idle, which the block leaves unchecked
      if (csr_we) begin
         unique case (csr_addr)
            tvp_pkg::CSR_SEG_LEN:   seg_len_in  = csr_wdata[DW-1:0];
            tvp_pkg::CSR_SPD_LIM:   spd_lim_in  = csr_wdata[SW-1:0];
            tvp_pkg::CSR_ACC_LIM:   acc_lim_in  = csr_wdata[SW-1:0];
            tvp_pkg::CSR_TIME_STEP: t_step_in   = csr_wdata[TW-1:0];
            tvp_pkg::CSR_MODE:      mode_in     = csr_wdata[0];
            tvp_pkg::CSR_TURN_DIR:  turn_dir_in = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         tvp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tdata[0]) begin
                  dist_in     = '0;
                  spd_now_in  = '0;
                  spd_prev_in = '0;
               end
               state_in = tvp_pkg::ST_CHECK;
            end
         end

         tvp_pkg::ST_CHECK: begin
            if (dist_ff >= seg_len_ff) begin
               // segment finished: state untouched, fixed result
               pend_lin_in  = '0;
               pend_ang_in  = '0;
               pend_done_in = 1'b1;
               phase_in     = tvp_pkg::PH_DECEL;
               state_in     = tvp_pkg::ST_OUT;
            end else begin
               // (prev + now) * dt for the trapezoid step
               mul_start  = 1'b1;
               mul_mcand  = {6'b0, {1'b0, spd_prev_ff} + {1'b0, spd_now_ff}};
               mul_mplier = {2'b0, t_step_ff};
               state_in   = tvp_pkg::ST_MUL_DIST;
            end
         end

         tvp_pkg::ST_MUL_DIST: begin
            if (mul_done) begin
               dist_in     = dist_sum[DW] ? '1 : dist_sum[DW-1:0];
               spd_prev_in = spd_now_ff;
               mul_start   = 1'b1;
               mul_mcand   = {7'b0, spd_now_ff};
               mul_mplier  = {2'b0, t_step_ff};
               state_in    = tvp_pkg::ST_MUL_LOOK;
            end
         end

         tvp_pkg::ST_MUL_LOOK: begin
            if (mul_done) begin
               look_in    = {1'b0, dist_ff} + {7'b0, mul_product[33:16]};
               mul_start  = 1'b1;
               mul_mcand  = {7'b0, spd_lim_ff};
               mul_mplier = spd_lim_ff;
               state_in   = tvp_pkg::ST_MUL_VV;
            end
         end

         tvp_pkg::ST_MUL_VV: begin
            if (mul_done) begin
               div_start = 1'b1;
               div_num   = mul_product[35:0];
               div_den   = {acc_eff, 1'b0};
               state_in  = tvp_pkg::ST_DIV_RAMP;
            end
         end

         tvp_pkg::ST_DIV_RAMP: begin
            if (div_done) begin
               ramp_in  = div_quot[tvp_pkg::RAMP_W-1:0];
               state_in = tvp_pkg::ST_ENDS;
            end
         end

         tvp_pkg::ST_ENDS: begin
            // ramp fits 24 bits whenever 2*ramp <= L
            if (short_seg) begin
               acc_end_in = {1'b0, seg_len_ff[DW-1:1]};
               cru_end_in = {1'b0, seg_len_ff[DW-1:1]};
            end else begin
               acc_end_in = ramp_ff[DW-1:0];
               cru_end_in = seg_len_ff - ramp_ff[DW-1:0];
            end
            mul_start  = 1'b1;
            mul_mcand  = {7'b0, acc_eff};
            mul_mplier = {2'b0, t_step_ff};
            state_in   = tvp_pkg::ST_MUL_ADT;
         end

         tvp_pkg::ST_MUL_ADT: begin
            if (mul_done) begin
               step_up_in = mul_product[33:16];
               // floor(6*a*dt / (5*2^16)) = floor(floor(6*a*dt / 2^16) / 5)
               div_start  = 1'b1;
               div_num    = {15'b0, six_adt[36:16]};
               div_den    = tvp_pkg::STEP_DN_DIVISOR;
               state_in   = tvp_pkg::ST_DIV_DOWN;
            end
         end

         tvp_pkg::ST_DIV_DOWN: begin
            if (div_done) begin
               step_dn_in = div_quot[tvp_pkg::STEP_DN_W-1:0];
               state_in   = tvp_pkg::ST_PHASE;
            end
         end

         tvp_pkg::ST_PHASE: begin
            if (look_ff < {1'b0, acc_end_ff}) begin
               phase_in   = tvp_pkg::PH_ACCEL;
               mul_start  = 1'b1;
               mul_mcand  = look_ff;
               mul_mplier = acc_eff;
               state_in   = tvp_pkg::ST_MUL_ROOT;
            end else if (look_ff < {1'b0, cru_end_ff}) begin
               phase_in = tvp_pkg::PH_CRUISE;
               sched_in = {4'b0, spd_lim_ff};
               state_in = tvp_pkg::ST_STEP;
            end else begin
               phase_in = tvp_pkg::PH_DECEL;
               if (look_ff >= {1'b0, seg_len_ff}) begin
                  sched_in = '0;
                  state_in = tvp_pkg::ST_STEP;
               end else begin
                  mul_start  = 1'b1;
                  mul_mcand  = {1'b0, seg_len_ff - look_ff[DW-1:0]};
                  mul_mplier = acc_eff;
                  state_in   = tvp_pkg::ST_MUL_ROOT;
               end
            end
         end

         tvp_pkg::ST_MUL_ROOT: begin
            if (mul_done) begin
               sqrt_start = 1'b1;
               sqrt_rad   = {mul_product, 1'b0};
               state_in   = tvp_pkg::ST_SQRT;
            end
         end

         tvp_pkg::ST_SQRT: begin
            if (sqrt_done) begin
               // accel schedule never drops below one speed step
               if ((phase_ff == tvp_pkg::PH_ACCEL) && (sqrt_root < {4'b0, step_up_ff})) begin
                  sched_in = {4'b0, step_up_ff};
               end else begin
                  sched_in = sqrt_root;
               end
               state_in = tvp_pkg::ST_STEP;
            end
         end

         tvp_pkg::ST_STEP: begin
            spd_now_in   = cmd;
            pend_lin_in  = mode_ff ? '0 : cmd;
            pend_ang_in  = !mode_ff ? '0 :
                           (turn_dir_ff ? (AW'(0) - {1'b0, cmd}) : {1'b0, cmd});
            pend_done_in = (dist_ff >= seg_len_ff);
            state_in     = tvp_pkg::ST_OUT;
         end

         tvp_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b0, pend_ang_ff, pend_lin_ff};
               rsp_last_in  = pend_done_ff;
               rsp_user_in  = phase_ff;
               state_in     = tvp_pkg::ST_IDLE;
            end
         end

         default: state_in = tvp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tvp_pkg::ST_IDLE;
         seg_len_ff   <= tvp_pkg::SEG_LEN_RST;
         spd_lim_ff   <= tvp_pkg::SPD_LIM_RST;
         acc_lim_ff   <= tvp_pkg::ACC_LIM_RST;
         t_step_ff    <= tvp_pkg::TIME_STEP_RST;
         mode_ff      <= 1'b0;
         turn_dir_ff  <= 1'b0;
         dist_ff      <= '0;
         spd_now_ff   <= '0;
         spd_prev_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_len_ff   <= seg_len_in;
         spd_lim_ff   <= spd_lim_in;
         acc_lim_ff   <= acc_lim_in;
         t_step_ff    <= t_step_in;
         mode_ff      <= mode_in;
         turn_dir_ff  <= turn_dir_in;
         dist_ff      <= dist_in;
         spd_now_ff   <= spd_now_in;
         spd_prev_ff  <= spd_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff     <= phase_in;
      look_ff      <= look_in;
      ramp_ff      <= ramp_in;
      acc_end_ff   <= acc_end_in;
      cru_end_ff   <= cru_end_in;
      step_up_ff   <= step_up_in;
      step_dn_ff   <= step_dn_in;
      sched_ff     <= sched_in;
      pend_lin_ff  <= pend_lin_in;
      pend_ang_ff  <= pend_ang_in;
      pend_done_ff <= pend_done_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* rtl/tvp_mul.sv */
// ----------------------------------------------------------------------------
// tvp_mul
// Bit-serial shift-and-add multiplier, multiplier LSB first, one partial
// product per cycle. done pulses one cycle; product holds until next start.
// ----------------------------------------------------------------------------
module tvp_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tvp_pkg::MUL_MC_W-1:0] mcand,
   input  logic [tvp_pkg::MUL_MP_W-1:0] mplier,
   output logic                         done,
   output logic [tvp_pkg::MUL_PR_W-1:0] product
);

   localparam int MC = tvp_pkg::MUL_MC_W;
   localparam int MP = tvp_pkg::MUL_MP_W;
   localparam int CW = tvp_pkg::MUL_CNT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [MC-1:0] mc_ff, mc_in;
   logic [MC-1:0] hi_ff, hi_in;
   logic [MP-1:0] lo_ff, lo_in;
   logic [MC:0]   sum;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mc_in   = mc_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mc_ff} : '0);
      if (busy_ff) begin
         hi_in  = sum[MC:1];
         lo_in  = {sum[0], lo_ff[MP-1:1]};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(MP - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         mc_in   = mcand;
         hi_in   = '0;
         lo_in   = mplier;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mc_ff <= mc_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

/* rtl/tvp_div.sv */
// ----------------------------------------------------------------------------
// tvp_div
// Restoring bit-serial divider, one quotient bit per cycle. The numerator
// register shifts out at the top and collects the quotient at the bottom.
// ----------------------------------------------------------------------------
module tvp_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tvp_pkg::DIV_NUM_W-1:0] num,
   input  logic [tvp_pkg::DIV_DEN_W-1:0] den,
   output logic                          done,
   output logic [tvp_pkg::DIV_NUM_W-1:0] quot
);

   localparam int NW = tvp_pkg::DIV_NUM_W;
   localparam int DW = tvp_pkg::DIV_DEN_W;
   localparam int CW = tvp_pkg::DIV_CNT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] q_ff, q_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, q_ff[NW-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = (trial >= {1'b0, den_ff});
      if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         q_in   = {q_ff[NW-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

/* rtl/tvp_sqrt.sv */
// ----------------------------------------------------------------------------
// tvp_sqrt
// Digit-by-digit integer square root (floor), two radicand bits in and one
// root bit out per cycle.
// ----------------------------------------------------------------------------
module tvp_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [tvp_pkg::SQRT_RAD_W-1:0]  rad,
   output logic                            done,
   output logic [tvp_pkg::SQRT_ROOT_W-1:0] root
);

   localparam int RW = tvp_pkg::SQRT_RAD_W;
   localparam int OW = tvp_pkg::SQRT_ROOT_W;
   localparam int MW = tvp_pkg::SQRT_REM_W;
   localparam int CW = tvp_pkg::SQRT_CNT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] rad_ff, rad_in;
   logic [MW-1:0] rem_ff, rem_in;
   logic [OW-1:0] root_ff, root_in;
   logic [MW-1:0] cur;
   logic [MW-1:0] trial;
   logic          ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cur     = {rem_ff[MW-3:0], rad_ff[RW-1:RW-2]};
      trial   = {1'b0, root_ff, 2'b01};
      ge      = (cur >= trial);
      if (busy_ff) begin
         rem_in  = ge ? (cur - trial) : cur;
         root_in = {root_ff[OW-2:0], ge};
         rad_in  = {rad_ff[RW-3:0], 2'b00};
         cnt_in  = cnt_ff + CW'(1);
         if (cnt_ff == CW'(OW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = rad;
         rem_in  = '0;
         root_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* rtl/tvp_checker.sv */
// ----------------------------------------------------------------------------
// tvp_checker
// Port-level checks for the velocity profiler, bound to the top level.
// ----------------------------------------------------------------------------
`include "trapezoidal_velocity_profiler_top_assert.svh"

module tvp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tvp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast,
   input logic [1:0]                      rsp_tuser
);

   logic lin_active;   // valid word with a nonzero linear command
   logic ang_idle;     // angular command is zero
   logic in_decel;     // word reports deceleration
   logic rsp_stall;    // result offered but not taken

   assign lin_active = rsp_tvalid && (rsp_tdata[17:0] != 18'd0);
   assign ang_idle   = (rsp_tdata[36:18] == 19'd0);
   assign in_decel   = (rsp_tuser == tvp_pkg::PH_DECEL);
   assign rsp_stall  = rsp_tvalid && !rsp_tready;

   // only one of the linear and angular commands is ever nonzero
   `TVP_ASSERT_NOW(a_one_channel, lin_active, ang_idle, "linear and angular both active")

   // a finished segment always reports deceleration
   `TVP_ASSERT_NOW(a_done_decel, rsp_tvalid && rsp_tlast, in_decel, "segment done outside decel")

   // one tick at a time: no word taken in back-to-back cycles
   `TVP_ASSERT_NEXT(a_one_tick, req_tvalid && req_tready, !req_tready, "second word taken")

   // a stalled result stays put
   `TVP_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "stalled word changed")

endmodule

bind trapezoidal_velocity_profiler_top tvp_checker u_tvp_checker (.*);
